### rtl/lpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types, codes and helpers for the LIKE pattern matcher.
// ----------------------------------------------------------------------------
package lpm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int NPOS        = MAX_PATTERN + 1;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [7:0] CHAR_RUN   = 8'h25;
    localparam logic [7:0] CHAR_ONE   = 8'h5F;
    localparam logic [7:0] ESC_RESET  = 8'h5C;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CHAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE = 1'd1;

    typedef enum logic [1:0] {
        OP_PAT_CHAR = 2'd0,
        OP_PAT_END  = 2'd1,
        OP_VAL_CHAR = 2'd2,
        OP_VAL_END  = 2'd3
    } lpm_op_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ESCAPE    = 2'd1,
        ERR_TOO_LONG  = 2'd2,
        ERR_NON_ASCII = 2'd3
    } lpm_err_t;

    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,
        KIND_ONE = 2'd1,
        KIND_RUN = 2'd2
    } lpm_kind_t;

    typedef enum logic {
        ANS_PATTERN = 1'b0,
        ANS_VALUE   = 1'b1
    } lpm_ans_t;

    typedef struct packed {
        lpm_op_t    opcode;
        logic [7:0] symbol;
    } lpm_in_t;

    typedef struct packed {
        lpm_ans_t answer_kind;
        logic     matched;
        lpm_err_t error_code;
    } lpm_out_t;

    // broadcast from the control block to every cell
    typedef struct packed {
        logic       act_init;
        logic       step;
        logic [7:0] sym;
        logic       ignore_case;
        lpm_kind_t  wr_kind;
        logic [7:0] wr_char;
    } lpm_cmd_t;

    function automatic logic [7:0] lpm_fold(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

### rtl/lpm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_cell
// One pattern position: stored element plus its active bit.
// ----------------------------------------------------------------------------
module lpm_cell
    import lpm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  lpm_cmd_t cmd,
    input  logic     wr_en,
    input  logic     valid,
    input  logic     init_val,
    input  logic     carry_in,
    input  logic     adv_in,
    output logic     carry_out,
    output logic     adv_out,
    output logic     closed
);

    lpm_kind_t  kind_reg;
    logic [7:0] char_reg;
    logic       act_reg;
    logic       act_next;
    logic       is_run;
    logic       hit;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            kind_reg <= cmd.wr_kind;
            char_reg <= cmd.wr_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= init_val;
        end else begin
            act_reg <= act_next;
        end
    end

    always_comb begin
        case (kind_reg)
            KIND_LIT: hit = (char_reg == cmd.sym) ||
                            (cmd.ignore_case && lpm_fold(char_reg) == lpm_fold(cmd.sym));
            KIND_ONE: hit = 1'b1;
            default:  hit = 1'b0;
        endcase
    end

    // a run never follows a run, so one step of closure is enough
    assign closed    = act_reg | carry_in;
    assign is_run    = valid && (kind_reg == KIND_RUN);
    assign carry_out = act_reg && is_run;
    assign adv_out   = closed && valid && hit;

    always_comb begin
        if (cmd.act_init) begin
            act_next = init_val;
        end else if (cmd.step) begin
            act_next = (closed && is_run) || adv_in;
        end else begin
            act_next = act_reg;
        end
    end

endmodule

### rtl/lpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_ctrl
// Pattern loader, fault tracking, config registers and result register.
// ----------------------------------------------------------------------------
module lpm_ctrl
    import lpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lpm_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lpm_out_t             m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 hit,
    output logic [CNT_W-1:0]     count,
    output logic                 push,
    output logic [CNT_W-1:0]     wr_index,
    output lpm_cmd_t             cmd
);

    logic [7:0]       esc_char_reg;
    logic             ign_case_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_run_reg, last_run_next;
    logic             esc_pend_reg, esc_pend_next;
    lpm_err_t         pfault_reg, pfault_next;
    logic             sealed_reg, sealed_next;
    logic             vfault_reg, vfault_next;
    logic             m_valid_reg, m_valid_next;
    lpm_out_t         m_data_reg, m_data_next;

    logic             accept;
    logic             clr;
    logic             do_push;
    lpm_kind_t        push_kind;
    logic [7:0]       push_char;
    logic [CNT_W-1:0] push_idx;
    lpm_err_t         perr;
    lpm_err_t         verr;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign count   = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_char_reg <= ESC_RESET;
            ign_case_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ESCAPE_CHAR: esc_char_reg <= cfg_data;
                CFG_IGNORE_CASE: ign_case_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            last_run_reg <= 1'b0;
            esc_pend_reg <= 1'b0;
            pfault_reg   <= ERR_NONE;
            sealed_reg   <= 1'b0;
            vfault_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            last_run_reg <= last_run_next;
            esc_pend_reg <= esc_pend_next;
            pfault_reg   <= pfault_next;
            sealed_reg   <= sealed_next;
            vfault_reg   <= vfault_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_comb begin
        if (pfault_reg == ERR_NON_ASCII) begin
            perr = ERR_NON_ASCII;
        end else if (esc_pend_reg) begin
            perr = ERR_ESCAPE;
        end else begin
            perr = pfault_reg;
        end
        verr = (perr == ERR_NONE && vfault_reg) ? ERR_NON_ASCII : perr;
    end

    // pattern loading
    always_comb begin
        cnt_next      = cnt_reg;
        last_run_next = last_run_reg;
        esc_pend_next = esc_pend_reg;
        pfault_next   = pfault_reg;
        sealed_next   = sealed_reg;
        vfault_next   = vfault_reg;
        clr           = 1'b0;
        do_push       = 1'b0;
        push_kind     = KIND_LIT;
        push_char     = s_data.symbol;
        push_idx      = cnt_reg;

        if (accept) begin
            case (s_data.opcode)
                OP_PAT_CHAR: begin
                    if (sealed_reg) begin
                        clr           = 1'b1;
                        sealed_next   = 1'b0;
                        cnt_next      = '0;
                        last_run_next = 1'b0;
                        esc_pend_next = 1'b0;
                        pfault_next   = ERR_NONE;
                        vfault_next   = 1'b0;
                    end
                    if (s_data.symbol[7]) begin
                        pfault_next = ERR_NON_ASCII;
                    end
                    if (esc_pend_next) begin
                        esc_pend_next = 1'b0;
                        do_push       = 1'b1;
                    end else if (s_data.symbol == esc_char_reg) begin
                        esc_pend_next = 1'b1;
                    end else if (s_data.symbol == CHAR_RUN) begin
                        do_push   = 1'b1;
                        push_kind = KIND_RUN;
                        push_char = '0;
                    end else if (s_data.symbol == CHAR_ONE) begin
                        do_push   = 1'b1;
                        push_kind = KIND_ONE;
                        push_char = '0;
                    end else begin
                        do_push = 1'b1;
                    end
                    // runs collapse into the previous run
                    if (push_kind == KIND_RUN && cnt_next != '0 && last_run_next) begin
                        do_push = 1'b0;
                    end
                    if (do_push && cnt_next >= CNT_W'(MAX_PATTERN)) begin
                        do_push = 1'b0;
                        if (pfault_next == ERR_NONE) begin
                            pfault_next = ERR_TOO_LONG;
                        end
                    end
                    if (do_push) begin
                        // a new pattern writes from slot zero
                        push_idx      = cnt_next;
                        cnt_next      = cnt_next + 1'b1;
                        last_run_next = (push_kind == KIND_RUN);
                    end
                end
                OP_PAT_END: begin
                    sealed_next = 1'b1;
                end
                OP_VAL_CHAR: begin
                    if (s_data.symbol[7]) begin
                        vfault_next = 1'b1;
                    end
                end
                OP_VAL_END: begin
                    vfault_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // cell commands
    always_comb begin
        push             = do_push;
        wr_index         = push_idx;
        cmd.act_init     = clr || (accept && s_data.opcode == OP_VAL_END);
        cmd.step         = accept && s_data.opcode == OP_VAL_CHAR;
        cmd.sym          = s_data.symbol;
        cmd.ignore_case  = ign_case_reg;
        cmd.wr_kind      = push_kind;
        cmd.wr_char      = push_char;
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept && s_data.opcode == OP_PAT_END) begin
            m_valid_next            = 1'b1;
            m_data_next.answer_kind = ANS_PATTERN;
            m_data_next.matched     = 1'b0;
            m_data_next.error_code  = perr;
        end else if (accept && s_data.opcode == OP_VAL_END) begin
            m_valid_next            = 1'b1;
            m_data_next.answer_kind = ANS_VALUE;
            m_data_next.matched     = (verr == ERR_NONE) && hit;
            m_data_next.error_code  = verr;
        end
    end

endmodule

### rtl/like_pattern_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// like_pattern_matcher
// SQL LIKE matcher: pattern elements held in a row of cells, value
// characters stepped through the cells as a bit-vector automaton.
// ----------------------------------------------------------------------------
//  channel  ports                          carries
//  s_       s_valid s_ready s_data         opcode, symbol
//  m_       m_valid m_ready m_data         answer_kind, matched, error_code
//  cfg_     cfg_wr_en cfg_index cfg_data   escape_char, ignore_case
//
//  on every value character all 65 position cells update together, each
//  using only its left neighbor's run carry and advance bit.
//  pattern end and value end items load the result register; s_ready is low
//  only while that register holds an item the sink has not taken.
//  synchronous active-low reset clears the loader and sets only position 0.
// ----------------------------------------------------------------------------
module like_pattern_matcher
    import lpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lpm_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lpm_out_t             m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    logic [CNT_W-1:0] count;
    logic             push;
    logic [CNT_W-1:0] wr_index;
    lpm_cmd_t         cmd;
    logic             hit;
    logic [NPOS-1:0]  carry;
    logic [NPOS-1:0]  adv;
    logic [NPOS-1:0]  closed;
    logic [NPOS-1:0]  end_hit;

    lpm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hit       (hit),
        .count     (count),
        .push      (push),
        .wr_index  (wr_index),
        .cmd       (cmd)
    );

    genvar i;
    generate
        for (i = 0; i < NPOS; i++) begin : g_cell
            logic c_in;
            logic a_in;
            logic init_v;
            if (i == 0) begin : g_first
                assign c_in   = 1'b0;
                assign a_in   = 1'b0;
                assign init_v = 1'b1;
            end else begin : g_rest
                assign c_in   = carry[i-1];
                assign a_in   = adv[i-1];
                assign init_v = 1'b0;
            end

            lpm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .wr_en     (push && wr_index == CNT_W'(i)),
                .valid     (count > CNT_W'(i)),
                .init_val  (init_v),
                .carry_in  (c_in),
                .adv_in    (a_in),
                .carry_out (carry[i]),
                .adv_out   (adv[i]),
                .closed    (closed[i])
            );

            // the end of the pattern sits at position count
            assign end_hit[i] = closed[i] && (count == CNT_W'(i));
        end
    endgenerate

    assign hit = |end_hit;

endmodule
